### sv/tgau_pkg.sv
// Shared types and constants for the tile id to atlas uv decoder.
// Used by tile_gid_atlas_uv_unit; no other dependencies.
`default_nettype none
package tgau_pkg;
   localparam int ID_W      = 29;
   localparam int LOCAL_W   = 16;
   localparam int COLS_W    = 13;
   localparam int TILE_W    = 11;
   localparam int GAP_W     = 8;
   localparam int IMG_W     = 15;
   localparam int UV_W      = 17;
   localparam int P_W       = 30;
   localparam int STEP_W    = TILE_W + 1;
   localparam int DIV_STEPS = 16;
   localparam int LANES     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 29;
   localparam int RSP_DAT_W = 160;

   localparam logic [GAP_W-1:0] ATLAS_MARGIN = '0;
   localparam logic [UV_W-1:0]  UV_ONE       = 17'h10000;

   localparam int HFLIP_BIT = 31;
   localparam int VFLIP_BIT = 30;
   localparam int DFLIP_BIT = 29;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BELOW = 2'd2,
      ST_OUT   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_ID = 3'd0,
      CSR_TOTAL    = 3'd1,
      CSR_COLUMNS  = 3'd2,
      CSR_TILE_W   = 3'd3,
      CSR_TILE_H   = 3'd4,
      CSR_GAP      = 3'd5,
      CSR_IMAGE_W  = 3'd6,
      CSR_IMAGE_H  = 3'd7
   } csr_idx_type;

   typedef struct packed {
      status_type           status;
      logic                 hf;
      logic                 vf;
      logic                 df;
      logic [LOCAL_W-1:0]   local_id;
   } meta_type;

   typedef struct packed {
      logic                 sat;
      logic [IMG_W-1:0]     rem;
      logic [DIV_STEPS-1:0] quo;
   } lane_type;
endpackage
`default_nettype wire

### sv/tile_gid_atlas_uv_unit.sv
// Tile map cell decoder: flip bits, tileset check, atlas uv corners.
// Depends on tgau_pkg.
//
// Usage:
//  req_ channel: one raw cell word per transfer (tdata = cell_word).
//  rsp_ channel: one result per accepted word: status, local_id and the
//    four corner uv pairs in unsigned 1.16.
//  csr_ channel: register index and data; always ready. Write only while
//    the pipeline is empty.
//  Throughput is one cell per cycle while rsp_tready does not stall: a
//  16-stage column/row divider, one multiply stage and a 16-stage restoring
//  divider with four lanes for the uv edges.
//  The whole pipeline advances when the output register is empty or being
//  taken; a stall on rsp_tready freezes every stage and drops req_tready.
//  Reset clears all valid bits and loads the register reset values.
`default_nettype none
module tile_gid_atlas_uv_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [31:0]                      req_tdata,  // cell_word
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // status, local_id, tr_u, tr_v, br_u, br_v, bl_u, bl_v, tl_u, tl_v, zero pad
   output logic [tgau_pkg::RSP_DAT_W-1:0]   rsp_tdata,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [tgau_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [tgau_pkg::CSR_DAT_W-1:0]   csr_data
);
   import tgau_pkg::*;

   logic [ID_W-1:0]    first_id_ff;
   logic [LOCAL_W-1:0] total_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [TILE_W-1:0]  tw_ff, th_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic [IMG_W-1:0]   iw_ff, ih_ff;

   logic [COLS_W-1:0]  cols;
   logic [IMG_W-1:0]   size_w, size_h;
   logic [STEP_W-1:0]  step_x, step_y;
   logic               en;

   assign csr_ready = 1'b1;
   assign cols   = (cols_ff == '0) ? COLS_W'(1) : cols_ff;
   assign size_w = (iw_ff == '0) ? IMG_W'(1) : iw_ff;
   assign size_h = (ih_ff == '0) ? IMG_W'(1) : ih_ff;
   assign step_x = STEP_W'(tw_ff) + STEP_W'(gap_ff);
   assign step_y = STEP_W'(th_ff) + STEP_W'(gap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff <= ID_W'(1);
         total_ff    <= '0;
         cols_ff     <= COLS_W'(1);
         tw_ff       <= '0;
         th_ff       <= '0;
         gap_ff      <= '0;
         iw_ff       <= IMG_W'(1);
         ih_ff       <= IMG_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FIRST_ID: first_id_ff <= csr_data[ID_W-1:0];
            CSR_TOTAL:    total_ff    <= csr_data[LOCAL_W-1:0];
            CSR_COLUMNS:  cols_ff     <= csr_data[COLS_W-1:0];
            CSR_TILE_W:   tw_ff       <= csr_data[TILE_W-1:0];
            CSR_TILE_H:   th_ff       <= csr_data[TILE_W-1:0];
            CSR_GAP:      gap_ff      <= csr_data[GAP_W-1:0];
            CSR_IMAGE_W:  iw_ff       <= csr_data[IMG_W-1:0];
            CSR_IMAGE_H:  ih_ff       <= csr_data[IMG_W-1:0];
            default:      ;
         endcase
      end
   end

   logic out_vld_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // ---- stage 0: decode and range check
   logic [ID_W-1:0] gid;
   logic [ID_W-1:0] local_full;
   meta_type        meta0_in;
   assign gid        = req_tdata[ID_W-1:0];
   assign local_full = gid - first_id_ff;

   always_comb begin
      meta0_in.hf       = req_tdata[HFLIP_BIT];
      meta0_in.vf       = req_tdata[VFLIP_BIT];
      meta0_in.df       = req_tdata[DFLIP_BIT];
      meta0_in.local_id = local_full[LOCAL_W-1:0];
      priority if (gid == '0)                             meta0_in.status = ST_EMPTY;
      else if (gid < first_id_ff)                         meta0_in.status = ST_BELOW;
      else if (local_full >= ID_W'(total_ff))             meta0_in.status = ST_OUT;
      else                                                meta0_in.status = ST_OK;
   end

   // ---- column / row divider, index 0 is the decode register
   logic                  dv_vld_ff [0:DIV_STEPS];
   meta_type              dv_meta_ff[0:DIV_STEPS];
   logic [LOCAL_W-1:0]    dv_num_ff [0:DIV_STEPS];
   logic [COLS_W-1:0]     dv_rem_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else if (en) dv_vld_ff[0] <= req_tvalid;
      if (en) begin
         dv_meta_ff[0] <= meta0_in;
         dv_num_ff[0]  <= meta0_in.local_id;
         dv_rem_ff[0]  <= '0;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_iddiv
      logic [COLS_W:0] trial;
      logic            take;
      assign trial = {dv_rem_ff[k-1], dv_num_ff[k-1][LOCAL_W-1]};
      assign take  = trial >= {1'b0, cols};
      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[k] <= 1'b0;
         else if (en) dv_vld_ff[k] <= dv_vld_ff[k-1];
         if (en) begin
            dv_meta_ff[k] <= dv_meta_ff[k-1];
            dv_num_ff[k]  <= {dv_num_ff[k-1][LOCAL_W-2:0], take};
            dv_rem_ff[k]  <= take ? COLS_W'(trial - {1'b0, cols}) : trial[COLS_W-1:0];
         end
      end
   end

   // ---- multiply stage: texel origin
   logic           mu_vld_ff;
   meta_type       mu_meta_ff;
   logic [P_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) mu_vld_ff <= 1'b0;
      else if (en) mu_vld_ff <= dv_vld_ff[DIV_STEPS];
      if (en) begin
         mu_meta_ff <= dv_meta_ff[DIV_STEPS];
         px_ff <= P_W'(dv_rem_ff[DIV_STEPS] * step_x) + P_W'(ATLAS_MARGIN);
         py_ff <= P_W'(dv_num_ff[DIV_STEPS] * step_y) + P_W'(ATLAS_MARGIN);
      end
   end

   // ---- edge divider, four lanes: umin, umax, v at py, v at py + tile_h
   logic     ed_vld_ff [0:DIV_STEPS];
   meta_type ed_meta_ff[0:DIV_STEPS];
   lane_type ed_lane_ff[0:DIV_STEPS][LANES];

   logic [P_W-1:0]   lane_p   [LANES];
   logic [IMG_W-1:0] lane_size[LANES];
   assign lane_p[0]    = px_ff;
   assign lane_p[1]    = px_ff + P_W'(tw_ff);
   assign lane_p[2]    = py_ff;
   assign lane_p[3]    = py_ff + P_W'(th_ff);
   assign lane_size[0] = size_w;
   assign lane_size[1] = size_w;
   assign lane_size[2] = size_h;
   assign lane_size[3] = size_h;

   always_ff @(posedge clock) begin
      if (reset) ed_vld_ff[0] <= 1'b0;
      else if (en) ed_vld_ff[0] <= mu_vld_ff;
      if (en) ed_meta_ff[0] <= mu_meta_ff;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_prep
      always_ff @(posedge clock) begin
         if (en) begin
            ed_lane_ff[0][l].sat <= lane_p[l] >= P_W'(lane_size[l]);
            ed_lane_ff[0][l].rem <= lane_p[l][IMG_W-1:0];
            ed_lane_ff[0][l].quo <= '0;
         end
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_eddiv
      always_ff @(posedge clock) begin
         if (reset) ed_vld_ff[k] <= 1'b0;
         else if (en) ed_vld_ff[k] <= ed_vld_ff[k-1];
         if (en) ed_meta_ff[k] <= ed_meta_ff[k-1];
      end
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [IMG_W:0] trial;
         logic           take;
         assign trial = {ed_lane_ff[k-1][l].rem, 1'b0};
         assign take  = trial >= {1'b0, lane_size[l]};
         always_ff @(posedge clock) begin
            if (en) begin
               ed_lane_ff[k][l].sat <= ed_lane_ff[k-1][l].sat;
               ed_lane_ff[k][l].rem <= take ? IMG_W'(trial - {1'b0, lane_size[l]})
                                            : trial[IMG_W-1:0];
               ed_lane_ff[k][l].quo <= {ed_lane_ff[k-1][l].quo[DIV_STEPS-2:0], take};
            end
         end
      end
   end

   // ---- output register: flips and corner select
   logic [UV_W-1:0] edge_v[LANES];
   logic [UV_W-1:0] umin, umax, vmin, vmax;
   meta_type        fm;
   logic            ok;
   for (genvar l = 0; l < LANES; l++) begin : g_edge
      assign edge_v[l] = ed_lane_ff[DIV_STEPS][l].sat ? UV_ONE
                         : {1'b0, ed_lane_ff[DIV_STEPS][l].quo};
   end
   assign fm   = ed_meta_ff[DIV_STEPS];
   assign ok   = fm.status == ST_OK;
   assign umin = edge_v[0];
   assign umax = edge_v[1];
   assign vmax = UV_ONE - edge_v[2];
   assign vmin = UV_ONE - edge_v[3];

   function automatic logic [2*UV_W-1:0] corner_uv(
      input logic x, input logic y, input meta_type m,
      input logic [UV_W-1:0] u0, input logic [UV_W-1:0] u1,
      input logic [UV_W-1:0] v0, input logic [UV_W-1:0] v1);
      logic xs, ys;
      xs = (m.df ? y : x) ^ m.hf;
      ys = (m.df ? x : y) ^ m.vf;
      return {(ys ? v1 : v0), (xs ? u1 : u0)};
   endfunction

   logic [2*UV_W-1:0] tr, br, bl, tl;
   assign tr = corner_uv(1'b1, 1'b1, fm, umin, umax, vmin, vmax);
   assign br = corner_uv(1'b1, 1'b0, fm, umin, umax, vmin, vmax);
   assign bl = corner_uv(1'b0, 1'b0, fm, umin, umax, vmin, vmax);
   assign tl = corner_uv(1'b0, 1'b1, fm, umin, umax, vmin, vmax);

   status_type         o_status_ff;
   logic [LOCAL_W-1:0] o_local_ff;
   logic [2*UV_W-1:0]  o_tr_ff, o_br_ff, o_bl_ff, o_tl_ff;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= ed_vld_ff[DIV_STEPS];
      if (en) begin
         o_status_ff <= fm.status;
         o_local_ff  <= ok ? fm.local_id : '0;
         o_tr_ff     <= ok ? tr : '0;
         o_br_ff     <= ok ? br : '0;
         o_bl_ff     <= ok ? bl : '0;
         o_tl_ff     <= ok ? tl : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, o_tl_ff, o_bl_ff, o_br_ff, o_tr_ff, o_local_ff, o_status_ff};

   // corners on a diagonal always cover the umin and the umax edge
   a_usum: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && o_status_ff == ST_OK |->
      ({1'b0, o_tr_ff[UV_W-1:0]} + {1'b0, o_bl_ff[UV_W-1:0]}) ==
      ({1'b0, o_br_ff[UV_W-1:0]} + {1'b0, o_tl_ff[UV_W-1:0]}))
      else $error("corner u edges inconsistent");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && o_status_ff != ST_OK |->
      o_local_ff == '0 && o_tr_ff == '0 && o_bl_ff == '0)
      else $error("error result carries nonzero payload");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en && dv_vld_ff[DIV_STEPS] |=> dv_vld_ff[DIV_STEPS] && $stable(dv_num_ff[DIV_STEPS]))
      else $error("divider stage changed during stall");

   a_uv_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> o_tr_ff[UV_W-1:0] <= UV_ONE && o_tr_ff[2*UV_W-1:UV_W] <= UV_ONE)
      else $error("uv out of range");
endmodule
`default_nettype wire
